>>> rtl/spdp_pkg.sv
package spdp_pkg;

  // Fixed shape of one item
  localparam int Lanes       = 8;
  localparam int Projections = 6;
  localparam int ElemBits    = 16;
  localparam int ProdBits    = 2 * ElemBits;
  localparam int LaneSumBits = ProdBits + $clog2(Lanes);
  localparam int AccBits     = 48;

  // Field and register widths
  localparam int CommandBits  = 1;
  localparam int ProjBits     = 3;
  localparam int ChunkBits    = 7;
  localparam int ChunkCfgBits = 8;
  localparam int VecCountBits = 16;
  localparam int CfgIndexBits = 1;
  localparam int CfgDataBits  = 16;

  // Result queue between the accumulators and the output port
  localparam int ResultDepth = 8;
  localparam int ResPtrBits  = $clog2(ResultDepth);
  localparam int ResCntBits  = ResPtrBits + 1;

  typedef enum logic [CommandBits-1:0] {
    CmdLoad = 1'b0,
    CmdData = 1'b1
  } command_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgChunksPerVector = 1'b0,
    CfgVectorCount     = 1'b1
  } cfg_reg_e;

  typedef logic signed [ElemBits-1:0] elem_t;
  typedef elem_t [Lanes-1:0] lane_vec_t;
  typedef logic signed [AccBits-1:0] acc_t;
  typedef acc_t [Projections-1:0] sum_vec_t;

  // Control that travels alongside a data chunk through the lanes
  typedef struct packed {
    logic valid;
    logic last_chunk;
    logic last_vector;
  } stage_ctl_t;

  typedef struct packed {
    sum_vec_t sums;
    logic     last_vector;
  } result_t;

endpackage

>>> rtl/spdp_ram.sv
module spdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/spdp_proj_unit.sv
module spdp_proj_unit
  import spdp_pkg::*;
#(
  parameter int CHUNK_DEPTH = 128
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                wr_en,
  input  logic [(CHUNK_DEPTH > 1 ? $clog2(CHUNK_DEPTH) : 1)-1:0] wr_addr,
  input  lane_vec_t                                           wr_lanes,
  input  logic [(CHUNK_DEPTH > 1 ? $clog2(CHUNK_DEPTH) : 1)-1:0] rd_addr,
  input  lane_vec_t                                           x,
  input  stage_ctl_t                                          ctl,
  output acc_t                                                sum
);

  localparam int LaneVecBits = Lanes * ElemBits;

  logic [LaneVecBits-1:0]        coef_raw;
  lane_vec_t                     coef;
  logic signed [ProdBits-1:0]    prod [Lanes];
  logic signed [LaneSumBits-1:0] lane_sum;
  logic signed [LaneSumBits-1:0] lane_sum_next;
  acc_t                          acc;

  // Coefficients of this projection, one row per chunk, all lanes wide
  spdp_ram #(
    .WIDTH (LaneVecBits),
    .DEPTH (CHUNK_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_lanes),
    .raddr (rd_addr),
    .rdata (coef_raw)
  );

  assign coef = lane_vec_t'(coef_raw);

  // Multiply each lane by its coefficient
  always_ff @(posedge clk) begin
    for (int l = 0; l < Lanes; l++) begin
      prod[l] <= $signed(coef[l]) * $signed(x[l]);
    end
  end

  // Add the lane products
  always_comb begin
    lane_sum_next = '0;
    for (int l = 0; l < Lanes; l++) begin
      lane_sum_next = lane_sum_next + LaneSumBits'(prod[l]);
    end
  end

  always_ff @(posedge clk) begin
    lane_sum <= lane_sum_next;
  end

  // Running total including the chunk now at the accumulator stage
  assign sum = acc + AccBits'(lane_sum);

  // Accumulate; clear once the vector's last chunk is in
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.valid) begin
      acc <= ctl.last_chunk ? '0 : sum;
    end
  end

endmodule

>>> rtl/spdp_result_fifo.sv
module spdp_result_fifo
  import spdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output logic    rd_valid,
  output result_t rd_data
);

  result_t               mem [ResultDepth];
  logic [ResPtrBits-1:0] wr_ptr;
  logic [ResPtrBits-1:0] rd_ptr;
  logic [ResCntBits-1:0] count;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  // Store finished results; room is guaranteed by the input credit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/six_way_projection_dot_product.sv
// Six-way projection dot product. Each input item is either a coefficient
// load (command 0: eight Q1.15 coefficients of one projection at one chunk
// position) or a data chunk (command 1: eight Q1.15 vector elements). The
// block takes one item per clock cycle while in_ready is high, loads and
// data alike, with no gaps between vectors. Six projection lanes each hold
// their coefficients in a RAM one chunk wide, multiply the eight elements
// in parallel and keep an exact 48-bit accumulator. After chunks_per_vector
// data chunks the six sums and the batch-closing flag leave as one result;
// the last chunk passes through the RAM read, multiply and lane add
// registers, then its accumulated sums are written into the queue. Finished
// results wait in an eight-entry queue, so input keeps flowing while the
// output side stalls, until eight results are pending.
// Configuration writes are always taken.
module six_way_projection_dot_product
  import spdp_pkg::*;
#(
  parameter int VECTOR_MAX = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CfgIndexBits-1:0]        cfg_index,
  input  logic [CfgDataBits-1:0]         cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CommandBits-1:0]         command,
  input  logic [ProjBits-1:0]            projection,
  input  logic [ChunkBits-1:0]           chunk_index,
  input  logic signed [ElemBits-1:0]     value0,
  input  logic signed [ElemBits-1:0]     value1,
  input  logic signed [ElemBits-1:0]     value2,
  input  logic signed [ElemBits-1:0]     value3,
  input  logic signed [ElemBits-1:0]     value4,
  input  logic signed [ElemBits-1:0]     value5,
  input  logic signed [ElemBits-1:0]     value6,
  input  logic signed [ElemBits-1:0]     value7,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [AccBits-1:0]      proj0,
  output logic signed [AccBits-1:0]      proj1,
  output logic signed [AccBits-1:0]      proj2,
  output logic signed [AccBits-1:0]      proj3,
  output logic signed [AccBits-1:0]      proj4,
  output logic signed [AccBits-1:0]      proj5,
  output logic                           last_vector
);

  localparam int ChunkCapRaw = VECTOR_MAX / Lanes;
  localparam int ChunkCap    = (ChunkCapRaw > 128) ? 128 : ChunkCapRaw;
  localparam int AddrBits    = (ChunkCap > 1) ? $clog2(ChunkCap) : 1;
  localparam logic [ChunkCfgBits-1:0] ChunkCapW = ChunkCfgBits'(ChunkCap);

  logic [ChunkCfgBits-1:0] chunks_per_vector;
  logic [VecCountBits-1:0] vector_count;
  logic [ChunkBits-1:0]    chunk_cnt;
  logic [VecCountBits-1:0] vector_cnt;
  logic [ResCntBits-1:0]   pending;

  logic [ChunkCfgBits-1:0] eff_chunks;
  logic [VecCountBits-1:0] eff_vectors;
  logic                    chunk_end;
  logic                    vec_last;
  logic                    in_xfer;
  logic                    data_xfer;
  logic                    load_ok;
  logic                    res_push;
  logic                    res_pop;

  lane_vec_t  in_lanes;
  lane_vec_t  s1_x;
  stage_ctl_t s1_ctl;
  stage_ctl_t s2_ctl;
  stage_ctl_t s3_ctl;
  sum_vec_t   sums;
  result_t    res_in;
  result_t    res_out;

  assign in_lanes = {value7, value6, value5, value4, value3, value2, value1, value0};

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_per_vector <= ChunkCfgBits'(1);
      vector_count      <= VecCountBits'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        CfgChunksPerVector: chunks_per_vector <= cfg_data[ChunkCfgBits-1:0];
        CfgVectorCount:     vector_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, chunks limited by the store
  always_comb begin
    if (chunks_per_vector == '0) begin
      eff_chunks = ChunkCfgBits'(1);
    end else if (chunks_per_vector > ChunkCapW) begin
      eff_chunks = ChunkCapW;
    end else begin
      eff_chunks = chunks_per_vector;
    end
    eff_vectors = (vector_count == '0) ? VecCountBits'(1) : vector_count;
  end

  assign chunk_end = (ChunkCfgBits'(chunk_cnt) + 1'b1) >= eff_chunks;
  assign vec_last  = ({1'b0, vector_cnt} + 1'b1) >= {1'b0, eff_vectors};

  // Input transfer; hold off once every queue slot is spoken for
  assign in_ready  = pending < ResCntBits'(ResultDepth);
  assign in_xfer   = in_valid && in_ready;
  assign data_xfer = in_xfer && (command == CmdData);
  assign load_ok   = in_xfer && (command == CmdLoad)
                     && (projection < ProjBits'(Projections))
                     && ({1'b0, chunk_index} < ChunkCapW);

  // Chunk and vector position
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_cnt  <= '0;
      vector_cnt <= '0;
    end else if (data_xfer) begin
      if (chunk_end) begin
        chunk_cnt  <= '0;
        vector_cnt <= vec_last ? '0 : vector_cnt + 1'b1;
      end else begin
        chunk_cnt <= chunk_cnt + 1'b1;
      end
    end
  end

  // Stage control alongside the RAM read, multiply and add stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else begin
      s1_ctl <= '{valid: data_xfer, last_chunk: chunk_end, last_vector: vec_last};
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (data_xfer) begin
      s1_x <= in_lanes;
    end
  end

  // One lane per projection
  for (genvar p = 0; p < Projections; p++) begin : g_proj
    spdp_proj_unit #(
      .CHUNK_DEPTH (ChunkCap)
    ) u_proj (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (load_ok && (projection == ProjBits'(p))),
      .wr_addr  (chunk_index[AddrBits-1:0]),
      .wr_lanes (in_lanes),
      .rd_addr  (chunk_cnt[AddrBits-1:0]),
      .x        (s1_x),
      .ctl      (s3_ctl),
      .sum      (sums[p])
    );
  end

  // Merge the lane sums into one result
  assign res_push = s3_ctl.valid && s3_ctl.last_chunk;
  assign res_in   = '{sums: sums, last_vector: s3_ctl.last_vector};
  assign res_pop  = out_valid && out_ready;

  spdp_result_fifo u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_push),
    .wr_data  (res_in),
    .rd_en    (res_pop),
    .rd_valid (out_valid),
    .rd_data  (res_out)
  );

  // Count results in flight or queued
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({data_xfer && chunk_end, res_pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  assign proj0       = res_out.sums[0];
  assign proj1       = res_out.sums[1];
  assign proj2       = res_out.sums[2];
  assign proj3       = res_out.sums[3];
  assign proj4       = res_out.sums[4];
  assign proj5       = res_out.sums[5];
  assign last_vector = res_out.last_vector;

endmodule
